// ===== sv/thi_pkg.sv =====
// shared types, constants and helpers for the trigram hash indexer
// depends on nothing; thi_dp, thi_ctrl and the top level use it by scoped names
package thi_pkg;

	// table geometry, capacity must be a power of two
	localparam int TABLE_SLOTS = 4096;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	typedef logic [SLOT_W-1:0] slot_t;

	localparam slot_t SLOT_MAX = slot_t'(TABLE_SLOTS - 1);

	// item opcodes
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// input item
	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [11:0] slot_index;
	} in_item_t;

	// result item
	typedef struct packed {
		logic        occupied;
		logic [23:0] trigram;
		logic [7:0]  follow_mask;
		logic [7:0]  place_mask;
		logic        status;
	} out_item_t;

	// one table slot as kept in memory
	typedef struct packed {
		logic        valid;
		logic [23:0] key;
		logic [7:0]  follow;
		logic [7:0]  place;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	// controller states
	typedef enum logic [3:0] {
		ST_INIT_SWEEP,
		ST_IDLE,
		ST_DECODE,
		ST_TAIL,
		ST_PROBE,
		ST_CHECK,
		ST_READ_WAIT,
		ST_CLEAR_SWEEP,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic shift;
		logic load_ins1;
		logic load_ins2;
		logic restart;
		logic probe_start;
		logic probe_step;
		logic read_issue;
		logic read_capture;
		logic sweep;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    seen_full;
		logic    last;
		logic    hit;
		logic    probe_last;
		logic    sweep_last;
	} dp_status_t;

	// home slot: the key xored with itself shifted right by one and by two bytes, masked to the table
	function automatic slot_t slot_hash(input logic [23:0] k);
		logic [23:0] x;
		x = (k >> 16) ^ (k >> 8) ^ k;
		return x[SLOT_W-1:0];
	endfunction

endpackage

// ===== sv/thi_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
module thi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/thi_dp.sv =====
// datapath: stream window, probe address and counters, slot memory, result register
// depends on thi_pkg and thi_ram
module thi_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  thi_pkg::in_item_t      request,
	input  thi_pkg::ctrl_cmd_t     cmd,
	output thi_pkg::dp_status_t    sts,
	output thi_pkg::out_item_t     result
);

	// latched item
	thi_pkg::opcode_t op_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [11:0]      idx_q;

	// stream state
	logic [23:0] recent_q;
	logic [1:0]  seen_q;
	logic [2:0]  pos_q;

	// insert under way
	logic [23:0]     key_q;
	logic [7:0]      fbit_q;
	logic [7:0]      pbit_q;
	thi_pkg::slot_t  probe_h_q;
	thi_pkg::slot_t  tries_q;
	thi_pkg::slot_t  sweep_q;

	thi_pkg::out_item_t result_q;

	// memory port
	thi_pkg::slot_t        ram_addr;
	logic                  ram_we;
	thi_pkg::slot_entry_t  ram_wdata;
	thi_pkg::slot_entry_t  ram_rdata;
	logic [thi_pkg::ENTRY_W-1:0] ram_rbits;

	logic        hit;
	logic        in_range;
	logic [31:0] idx_wide;

	assign idx_wide  = 32'(idx_q);
	assign in_range  = idx_wide < 32'(thi_pkg::TABLE_SLOTS);
	assign ram_rdata = thi_pkg::slot_entry_t'(ram_rbits);

	// probe outcome: free slot or matching key ends the probe
	assign hit = !ram_rdata.valid || (ram_rdata.key == key_q);

	// memory address, write enable and write data
	always_comb begin
		ram_addr  = thi_pkg::slot_t'(probe_h_q + 1'b1);
		ram_we    = 1'b0;
		ram_wdata = '0;
		if (cmd.sweep) begin
			ram_addr = sweep_q;
			ram_we   = 1'b1;
		end else if (cmd.probe_start) begin
			ram_addr = thi_pkg::slot_hash(key_q);
		end else if (cmd.probe_step && hit) begin
			ram_addr        = probe_h_q;
			ram_we          = 1'b1;
			ram_wdata.valid = 1'b1;
			ram_wdata.key   = key_q;
			ram_wdata.follow = ram_rdata.valid ? (ram_rdata.follow | fbit_q) : fbit_q;
			ram_wdata.place  = ram_rdata.valid ? (ram_rdata.place | pbit_q) : pbit_q;
		end else if (cmd.read_issue) begin
			ram_addr = idx_wide[thi_pkg::SLOT_W-1:0];
		end
	end

	thi_ram #(
		.WIDTH (thi_pkg::ENTRY_W),
		.DEPTH (thi_pkg::TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rbits)
	);

	// stream state and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q   <= '0;
			pos_q    <= '0;
			sweep_q  <= '0;
		end else begin
			if (cmd.restart) begin
				recent_q <= '0;
				seen_q   <= '0;
				pos_q    <= '0;
			end else begin
				if (cmd.load_ins1) begin
					pos_q <= pos_q + 3'd1;
				end
				if (cmd.shift) begin
					recent_q <= {recent_q[15:0], byte_q};
					if (seen_q != 2'd3) begin
						seen_q <= seen_q + 2'd1;
					end
				end
			end
			if (cmd.sweep) begin
				sweep_q <= thi_pkg::slot_t'(sweep_q + 1'b1);
			end
		end
	end

	// item latch, insert setup, probe counters and result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= request.opcode;
			byte_q   <= request.data_byte;
			last_q   <= request.last_byte;
			idx_q    <= request.slot_index;
			result_q <= '0;
		end
		if (cmd.restart) begin
			last_q <= 1'b0;
		end
		if (cmd.load_ins1) begin
			key_q  <= recent_q;
			fbit_q <= 8'b1 << byte_q[2:0];
			pbit_q <= 8'b1 << pos_q;
		end
		if (cmd.load_ins2) begin
			key_q  <= recent_q;
			fbit_q <= '0;
			pbit_q <= 8'b1 << pos_q;
		end
		if (cmd.probe_start) begin
			probe_h_q <= thi_pkg::slot_hash(key_q);
			tries_q   <= '0;
		end
		if (cmd.probe_step && !hit) begin
			probe_h_q <= thi_pkg::slot_t'(probe_h_q + 1'b1);
			tries_q   <= thi_pkg::slot_t'(tries_q + 1'b1);
			if (tries_q == thi_pkg::SLOT_MAX) begin
				result_q.status <= 1'b1;
			end
		end
		if (cmd.read_capture && in_range && ram_rdata.valid) begin
			result_q.occupied    <= 1'b1;
			result_q.trigram     <= ram_rdata.key;
			result_q.follow_mask <= ram_rdata.follow;
			result_q.place_mask  <= ram_rdata.place;
		end
	end

	// status back to the controller
	assign sts.op         = op_q;
	assign sts.seen_full  = seen_q == 2'd3;
	assign sts.last       = last_q;
	assign sts.hit        = hit;
	assign sts.probe_last = tries_q == thi_pkg::SLOT_MAX;
	assign sts.sweep_last = sweep_q == thi_pkg::SLOT_MAX;

	assign result = result_q;

	// a missed probe moves to the next slot
	a_probe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_step && !hit |=> probe_h_q == thi_pkg::slot_t'($past(probe_h_q) + 1'b1))
		else $error("probe address did not advance after a miss");

	// a sweep walks the table one slot a cycle
	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |=> sweep_q == thi_pkg::slot_t'($past(sweep_q) + 1'b1))
		else $error("sweep counter skipped a slot");

endmodule

// ===== sv/thi_ctrl.sv =====
// controller state machine for the trigram hash indexer
// depends on thi_pkg
module thi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  thi_pkg::dp_status_t  sts,
	output thi_pkg::ctrl_cmd_t   cmd,
	output logic                 busy,
	output logic                 done
);

	thi_pkg::state_t state_q;
	thi_pkg::state_t state_d;

	// state register, reset enters the table clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thi_pkg::ST_INIT_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			thi_pkg::ST_INIT_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = thi_pkg::ST_IDLE;
				end
			end
			thi_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = thi_pkg::ST_DECODE;
				end
			end
			thi_pkg::ST_DECODE: begin
				unique case (sts.op)
					thi_pkg::OP_PUSH: begin
						cmd.shift = 1'b1;
						if (sts.seen_full) begin
							cmd.load_ins1 = 1'b1;
							state_d       = thi_pkg::ST_PROBE;
						end else begin
							state_d = thi_pkg::ST_TAIL;
						end
					end
					thi_pkg::OP_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = thi_pkg::ST_READ_WAIT;
					end
					thi_pkg::OP_CLEAR: begin
						cmd.restart = 1'b1;
						state_d     = thi_pkg::ST_CLEAR_SWEEP;
					end
					default: begin
						state_d = thi_pkg::ST_FINISH;
					end
				endcase
			end
			// last byte: restart the stream and queue the final trigram if three bytes were seen; other bytes finish
			thi_pkg::ST_TAIL: begin
				if (sts.last) begin
					cmd.restart = 1'b1;
					if (sts.seen_full) begin
						cmd.load_ins2 = 1'b1;
						state_d       = thi_pkg::ST_PROBE;
					end else begin
						state_d = thi_pkg::ST_FINISH;
					end
				end else begin
					state_d = thi_pkg::ST_FINISH;
				end
			end
			thi_pkg::ST_PROBE: begin
				cmd.probe_start = 1'b1;
				state_d         = thi_pkg::ST_CHECK;
			end
			// one slot per cycle until free, matching, or the table is exhausted
			thi_pkg::ST_CHECK: begin
				cmd.probe_step = 1'b1;
				if (sts.hit || sts.probe_last) begin
					state_d = thi_pkg::ST_TAIL;
				end
			end
			thi_pkg::ST_READ_WAIT: begin
				cmd.read_capture = 1'b1;
				state_d          = thi_pkg::ST_FINISH;
			end
			thi_pkg::ST_CLEAR_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = thi_pkg::ST_FINISH;
				end
			end
			thi_pkg::ST_FINISH: begin
				state_d = thi_pkg::ST_IDLE;
			end
			default: begin
				state_d = thi_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != thi_pkg::ST_IDLE;
	assign done = state_q == thi_pkg::ST_FINISH;

	// an accepted item is decoded in the next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == thi_pkg::ST_IDLE && start |=> state_q == thi_pkg::ST_DECODE)
		else $error("accepted item not decoded");

	// a result is shown for one cycle, then the block is free again
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");

	// a successful probe always returns to the tail step
	a_hit_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == thi_pkg::ST_CHECK && sts.hit |=> state_q == thi_pkg::ST_TAIL)
		else $error("probe hit did not end the insert");

endmodule

// ===== sv/trigram_hash_indexer_unit.sv =====
// top level of the trigram hash indexer: controller plus datapath
// depends on thi_pkg, thi_ctrl, thi_dp (and thi_ram through the datapath)
//
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------
//  item in  | start, busy     | request (thi_pkg::in_item_t)
//  result   | done (strobe)   | result  (thi_pkg::out_item_t)
//
// an item is taken when start is high and busy is low; its result shows for one
// cycle with done high; no new item is taken before then. each trigram insert
// probes one slot a cycle through the single memory port. clear sweeps the table,
// one slot cleared a cycle; after reset the same clearing pass runs with busy high.
// the receiver cannot stall: every result is delivered in its done cycle.
module trigram_hash_indexer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  thi_pkg::in_item_t  request,
	output logic               busy,
	output logic               done,
	output thi_pkg::out_item_t result
);

	thi_pkg::ctrl_cmd_t  cmd;
	thi_pkg::dp_status_t sts;

	// sequencing
	thi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// table and stream datapath
	thi_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule
